// ===== sv/multilevel_priority_queue_bank_top_macros.svh =====
// Assertion helpers used by the control block (mlpqb_ctrl) of the priority queue bank.
// Each macro samples on the rising edge of aclk and is off during reset.
`ifndef MULTILEVEL_PRIORITY_QUEUE_BANK_TOP_MACROS_SVH
`define MULTILEVEL_PRIORITY_QUEUE_BANK_TOP_MACROS_SVH

// A condition that holds at every clock edge.
`define MLPQB_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// A condition that, once seen, forces another one in the next cycle.
`define MLPQB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mlpqb_pkg.sv =====
`timescale 1ns / 1ps

package mlpqb_pkg;

    // Bank geometry.
    localparam int QUEUE_DEPTH = 64;
    localparam int USER_LEVELS = 5;
    localparam int REF_WIDTH   = 16;
    localparam int NUM_QUEUES  = USER_LEVELS + 1;
    localparam int SLOT_COUNT  = NUM_QUEUES * QUEUE_DEPTH;

    // Derived widths.
    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int QSEL_W = $clog2(NUM_QUEUES);
    localparam int ADDR_W = $clog2(SLOT_COUNT);
    localparam int QID_W  = 3;
    localparam int STAT_W = 2;

    // Stream payload widths, padded to whole bytes.
    localparam int S_DATA_BITS = REF_WIDTH + 2 * QID_W;
    localparam int S_DATA_W    = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = REF_WIDTH + CNT_W;
    localparam int M_DATA_W    = ((M_DATA_BITS + 7) / 8) * 8;

    // Command codes.
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    // One access to the slot memory.
    typedef struct packed {
        logic                 wr_en;
        logic                 rd_en;
        logic [ADDR_W-1:0]    addr;
        logic [REF_WIDTH-1:0] wdata;
    } ram_req_t;

    // Outcome of one operation, known in the cycle of acceptance.
    typedef struct packed {
        status_t          status;
        logic [CNT_W-1:0] occ;
        logic             rd;
    } op_result_t;

endpackage

// ===== sv/multilevel_priority_queue_bank_top.sv =====
`timescale 1ns / 1ps
// Multilevel priority queue bank: one real-time queue and a set of user
// queues, each a circular FIFO of process references in a shared slot memory.
// Input channel (s_axis): tuser is the command (enqueue or dequeue); tdata
// carries the reference, the enqueue priority and the dequeue queue index.
// Output channel (m_axis): exactly one beat per input beat; tuser is the
// status, tdata the dequeued reference and the target queue's occupancy.
// The result beat passes through the memory stage, where the slot memory
// access completes, and then through the output register.
// Throughput: one beat per cycle while the receiver does not stall. Pointers and
// counts are updated in the cycle of acceptance, so the next beat sees them;
// the single slot memory port serves the one read or write each beat needs.
// Reset clears all pointers and counts, so every queue starts empty; slot
// contents are not cleared and need no clearing pass.
// When the receiver stalls, the result waits in the output register, one
// more beat waits in the memory stage, and then s_axis_tready drops.
module multilevel_priority_queue_bank_top
    import mlpqb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // process_ref, priority_req, queue_index (from bit 0 up), zero padded.
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // cmd.
    input  logic                s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // out_ref, occupancy (from bit 0 up), zero padded.
    output logic [M_DATA_W-1:0] m_axis_tdata,
    // status.
    output logic [STAT_W-1:0]   m_axis_tuser
);

    logic                 accept;
    ram_req_t             ram_req;
    op_result_t           result;
    logic [REF_WIDTH-1:0] rdata;

    logic                 s1_valid_reg;
    op_result_t           s1_res_reg;
    logic                 s1_move;
    logic                 out_move;

    logic                 m_valid_reg;
    status_t              m_status_reg;
    logic [REF_WIDTH-1:0] m_ref_reg;
    logic [CNT_W-1:0]     m_occ_reg;

    // Handshake: the memory stage frees up whenever it can pass its beat on.
    assign out_move      = !m_valid_reg || m_axis_tready;
    assign s1_move       = s1_valid_reg && out_move;
    assign s_axis_tready = !s1_valid_reg || out_move;
    assign accept        = s_axis_tvalid && s_axis_tready;

    mlpqb_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .cmd          (s_axis_tuser),
        .process_ref  (s_axis_tdata[REF_WIDTH-1:0]),
        .priority_req (s_axis_tdata[REF_WIDTH +: QID_W]),
        .queue_index  (s_axis_tdata[REF_WIDTH + QID_W +: QID_W]),
        .ram_req      (ram_req),
        .result       (result)
    );

    mlpqb_slot_ram u_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (rdata)
    );

    // Memory stage: holds the outcome while the slot read completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_move) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_res_reg <= result;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_move) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            m_status_reg <= s1_res_reg.status;
            m_ref_reg    <= s1_res_reg.rd ? rdata : '0;
            m_occ_reg    <= s1_res_reg.occ;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {{(M_DATA_W - M_DATA_BITS){1'b0}}, m_occ_reg, m_ref_reg};

endmodule

// ===== sv/mlpqb_slot_ram.sv =====
`timescale 1ns / 1ps

module mlpqb_slot_ram
    import mlpqb_pkg::*;
(
    input  logic                 aclk,
    input  ram_req_t             req,
    output logic [REF_WIDTH-1:0] rdata
);

    logic [REF_WIDTH-1:0] mem [SLOT_COUNT];
    logic [REF_WIDTH-1:0] rdata_reg;

    // Single-port slot store; read data is registered and holds between reads.
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en) begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/mlpqb_ctrl.sv =====
`timescale 1ns / 1ps
`include "multilevel_priority_queue_bank_top_macros.svh"

module mlpqb_ctrl
    import mlpqb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic                 cmd,
    input  logic [REF_WIDTH-1:0] process_ref,
    input  logic [QID_W-1:0]     priority_req,
    input  logic [QID_W-1:0]     queue_index,
    output ram_req_t             ram_req,
    output op_result_t           result
);

    logic [PTR_W-1:0] head_reg  [NUM_QUEUES];
    logic [PTR_W-1:0] head_next [NUM_QUEUES];
    logic [PTR_W-1:0] tail_reg  [NUM_QUEUES];
    logic [PTR_W-1:0] tail_next [NUM_QUEUES];
    logic [CNT_W-1:0] cnt_reg   [NUM_QUEUES];
    logic [CNT_W-1:0] cnt_next  [NUM_QUEUES];

    logic [QID_W-1:0]  target;
    logic              target_ok;
    logic [QSEL_W-1:0] qsel;
    logic [PTR_W-1:0]  ptr;
    logic [PTR_W-1:0]  ptr_adv;
    logic [CNT_W-1:0]  cnt_cur;

    // Pick the target queue and its current state.
    assign target    = (cmd == CMD_ENQUEUE) ? priority_req : queue_index;
    assign target_ok = (target <= QID_W'(USER_LEVELS));
    assign qsel      = QSEL_W'(target);
    assign cnt_cur   = target_ok ? cnt_reg[qsel] : '0;
    assign ptr       = (cmd == CMD_ENQUEUE) ? tail_reg[qsel] : head_reg[qsel];
    assign ptr_adv   = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);

    // Decide the operation and the pointer and count updates.
    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        cnt_next      = cnt_reg;
        ram_req.wr_en = 1'b0;
        ram_req.rd_en = 1'b0;
        ram_req.addr  = ADDR_W'(qsel) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr);
        ram_req.wdata = process_ref;
        result.status = ST_OK;
        result.occ    = '0;
        result.rd     = 1'b0;
        if (!target_ok) begin
            result.status = ST_INVALID;
        end else if (cmd == CMD_ENQUEUE) begin
            if (cnt_cur >= CNT_W'(QUEUE_DEPTH)) begin
                result.status = ST_FULL;
                result.occ    = cnt_cur;
            end else begin
                result.occ    = cnt_cur + CNT_W'(1);
                ram_req.wr_en = accept;
                if (accept) begin
                    tail_next[qsel] = ptr_adv;
                    cnt_next[qsel]  = cnt_cur + CNT_W'(1);
                end
            end
        end else begin
            if (cnt_cur == '0) begin
                result.status = ST_EMPTY;
            end else begin
                result.occ    = cnt_cur - CNT_W'(1);
                result.rd     = 1'b1;
                ram_req.rd_en = accept;
                if (accept) begin
                    head_next[qsel] = ptr_adv;
                    cnt_next[qsel]  = cnt_cur - CNT_W'(1);
                end
            end
        end
    end

    // Per-queue pointer and count registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    `MLPQB_ASSERT_ALWAYS(a_rw_exclusive, !(ram_req.wr_en && ram_req.rd_en), "slot read and write in one cycle")
    `MLPQB_ASSERT_ALWAYS(a_access_ok, !(ram_req.wr_en || ram_req.rd_en) || (result.status == ST_OK), "slot access on a failed operation")
    `MLPQB_ASSERT_NEXT(a_enq_count, accept && ram_req.wr_en && (qsel == QSEL_W'(0)), cnt_reg[0] == $past(result.occ), "enqueue count update lost")

endmodule
